### sv/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types, constants and the per-byte decode function of the UTF-8
// code point decoder.
// ----------------------------------------------------------------------------
package ucd_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PART_W = 15;
  localparam int unsigned NEED_W = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  // byte class masks and match values
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MATCH = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MATCH = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MATCH = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_MATCH = 8'hF0;

  // continuations still awaited after each lead kind
  localparam logic [NEED_W-1:0] NEED_NONE  = 2'd0;
  localparam logic [NEED_W-1:0] NEED_LEAD2 = 2'd1;
  localparam logic [NEED_W-1:0] NEED_LEAD3 = 2'd2;
  localparam logic [NEED_W-1:0] NEED_LEAD4 = 2'd3;

  // result of handling one byte against the pending state
  typedef struct packed {
    logic              got;
    logic [CP_W-1:0]   cp;
    logic [NEED_W-1:0] need;
    logic [PART_W-1:0] part;
  } ucd_step_t;

  function automatic ucd_step_t ucd_decode(
    input logic [BYTE_W-1:0] b,
    input logic              last,
    input logic [NEED_W-1:0] need,
    input logic [PART_W-1:0] part
  );
    ucd_step_t         res;
    logic [CP_W-1:0]   v;
    logic [NEED_W-1:0] need_dec;
    logic              is_cont;
    res      = '0;
    v        = {part, b[5:0]};
    need_dec = need - 2'd1;
    is_cont  = (b & CONT_MASK) == CONT_MATCH;

    if (need != NEED_NONE && is_cont) begin
      // continuation of a pending sequence
      res.need = need_dec;
      if (need_dec == NEED_NONE) begin
        res.got = 1'b1;
        res.cp  = v;
      end else begin
        res.part = v[PART_W-1:0];
      end
    end else begin
      // fresh byte, any pending sequence is dropped
      priority if (b[BYTE_W-1] == 1'b0) begin
        res.got = 1'b1;
        res.cp  = {{(CP_W-BYTE_W){1'b0}}, b};
      end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
        res.need = NEED_LEAD2;
        res.part = {{(PART_W-5){1'b0}}, b[4:0]};
      end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
        res.need = NEED_LEAD3;
        res.part = {{(PART_W-4){1'b0}}, b[3:0]};
      end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
        res.need = NEED_LEAD4;
        res.part = {{(PART_W-3){1'b0}}, b[2:0]};
      end else begin
        // stray continuation or invalid lead: dropped
        res.need = NEED_NONE;
      end
    end

    // end of string clears any incomplete sequence
    if (last) begin
      res.need = NEED_NONE;
      res.part = '0;
    end
    return res;
  endfunction

endpackage

### sv/utf8_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Lenient byte-at-a-time UTF-8 decoder emitting one code point per
// completed sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one text byte per transaction in in_tdata, with
//   in_tlast marking the final byte of a string. Output channel out_*: one
//   decoded code point per transaction in out_tdata[20:0].
//   A byte is captured in an input register, decoded by short logic against
//   the pending sequence state, and its code point (if any) lands in the
//   output register, which drives out_tvalid and out_tdata.
//   Throughput is one byte per cycle while out_tready stays high; the
//   pending-state register updates once per byte, which sets that rate.
//   Bytes that only open or extend a sequence, stray continuations and
//   bytes from 0xF8 up produce no output transaction. A sequence left
//   incomplete by the in_tlast byte is dropped.
//   When the receiver stalls, the output register holds its code point and
//   the input register holds the next byte; in_tready drops only when both
//   are full and out_tready is low.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   pending sequence.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder
  import ucd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] text_byte
  input  logic                   in_tlast,   // end_of_text
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [20:0] codepoint, [23:21] zero
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic [NEED_W-1:0] need_r;
  logic [PART_W-1:0] part_r;
  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;

  logic              s1_adv;
  logic              in_fire;
  ucd_step_t         step;

  // handshake: decode stage moves when the output slot is free or draining
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // decode of the registered byte
  assign step = ucd_decode(s1_byte_r, s1_last_r, need_r, part_r);

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // pending sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= NEED_NONE;
      part_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      need_r <= step.need;
      part_r <= step.part;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && step.got;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && step.got) begin
      out_cp_r <= step.cp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, out_cp_r};

  // no pending sequence survives the last byte of a string
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && s1_last_r |=> need_r == NEED_NONE)
    else $error("pending sequence kept after end of text");

  // partial payload width matches the number of awaited continuations
  assert property (@(posedge clk) disable iff (!rst_n)
    (need_r != NEED_NONE || part_r == '0) &&
    (need_r != NEED_LEAD4 || part_r[PART_W-1:3] == '0) &&
    (need_r != NEED_LEAD3 || part_r[PART_W-1:9] == '0))
    else $error("partial value too wide for pending state");

  // an ASCII byte comes out unchanged on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && !s1_byte_r[BYTE_W-1]
    |=> out_tvalid && out_tdata == {{(OUT_TDATA_W-BYTE_W){1'b0}}, $past(s1_byte_r)})
    else $error("ASCII byte not passed through");

  // a continuation completing the last awaited byte always emits
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && need_r == NEED_LEAD2 &&
    (s1_byte_r & CONT_MASK) == CONT_MATCH |=> out_tvalid)
    else $error("completed sequence not emitted");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the UTF-8 code point decoder by streaming bytes into it. A short
// table covers the byte classes, the largest code point and the ways a
// sequence can be broken. Random strings follow, mostly well formed. Every
// code point that comes out is compared with the table or a local decoder. Both sides
// idle in random bursts, and one long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import ucd_pkg::*;

  localparam int unsigned RANDOM_BYTES   = 950;
  localparam int unsigned CALM_FROM      = 830;
  localparam int unsigned LONG_HOLD_AT   = 300;
  localparam int unsigned LONG_HOLD_LEN  = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS    = 10;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation comes from the local decoder
    CHK_NONE,    // the byte must not produce a code point
    CHK_CP       // the code point is given in the row
  } row_check_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              eot;
    row_check_t        check;
    logic [CP_W-1:0]   cp;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;    // [7:0] text_byte
  logic                   in_tlast;    // end_of_text
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [20:0] codepoint, [23:21] zero

  // local decoder state
  logic [NEED_W-1:0] pend_cnt;
  logic [PART_W-1:0] pend_bits;

  stim_row_t       offer_q[$];
  stim_row_t       dir_rows[$];
  logic [CP_W-1:0] cp_expect_q[$];

  int unsigned fail_cnt;
  int unsigned accepted_cnt;
  int unsigned sent_cnt;
  int unsigned stall_cycles;
  int unsigned hold_cycles;
  bit          long_hold_done;
  bit          calm;

  utf8_codepoint_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stim_row_t mk_row(input logic [BYTE_W-1:0] b, input logic eot,
                                       input row_check_t chk, input logic [CP_W-1:0] cp);
    stim_row_t r;
    r.data  = b;
    r.eot   = eot;
    r.check = chk;
    r.cp    = cp;
    return r;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(input logic [BYTE_W-1:0] b, input logic eot,
                                  input row_check_t chk, input logic [CP_W-1:0] cp);
    dir_rows = {dir_rows, mk_row(b, eot, chk, cp)};
  endfunction

  // advances the local decoder by one byte, returns 1 when a code point completes
  function automatic bit decode_next_byte(input logic [BYTE_W-1:0] b, input logic eot,
                                          output logic [CP_W-1:0] cp);
    bit              got;
    logic [CP_W-1:0] acc;
    got = 1'b0;
    cp  = '0;
    acc = {pend_bits, b[5:0]};
    if (pend_cnt != NEED_NONE && (b & CONT_MASK) == CONT_MATCH) begin
      // continuation adds six payload bits
      pend_cnt = pend_cnt - 2'd1;
      if (pend_cnt == NEED_NONE) begin
        got       = 1'b1;
        cp        = acc;
        pend_bits = '0;
      end else begin
        pend_bits = acc[PART_W-1:0];
      end
    end else begin
      // any pending sequence is abandoned, byte is taken as fresh
      pend_cnt  = NEED_NONE;
      pend_bits = '0;
      if (b[BYTE_W-1] == 1'b0) begin
        got = 1'b1;
        cp  = CP_W'(b);
      end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
        pend_cnt  = NEED_LEAD2;
        pend_bits = PART_W'(b[4:0]);
      end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
        pend_cnt  = NEED_LEAD3;
        pend_bits = PART_W'(b[3:0]);
      end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
        pend_cnt  = NEED_LEAD4;
        pend_bits = PART_W'(b[2:0]);
      end
    end
    // end of string drops whatever is still open
    if (eot) begin
      pend_cnt  = NEED_NONE;
      pend_bits = '0;
    end
    return got;
  endfunction

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // idling is off in every third stretch and in the closing part
  function automatic bit may_idle();
    return !calm && ((accepted_cnt / 120) % 3 != 0);
  endfunction

  // offers one byte, returns at the falling edge after its transaction
  task automatic send_byte(input stim_row_t row);
    int unsigned gap;
    offer_q = {offer_q, row};
    if (may_idle() && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = row.data;
    in_tlast  = row.eot;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_cnt++;
  endtask

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_cycles    = LONG_HOLD_LEN - 1;
      out_tready     = 1'b0;
    end else if (may_idle() && $urandom_range(0, 7) == 0) begin
      hold_cycles = $urandom_range(0, 3);
      out_tready  = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // transaction monitor, checker and watchdog
  always @(posedge clk) begin
    logic [CP_W-1:0] cp_pred;
    logic [CP_W-1:0] want;
    stim_row_t       row;
    bit              got;
    if (rst_n) begin
      // result transaction against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (cp_expect_q.size() == 0) begin
          note_failure($sformatf("unexpected code point 0x%06h", out_tdata));
        end else begin
          want = cp_expect_q.pop_front();
          if (out_tdata !== {{(OUT_TDATA_W-CP_W){1'b0}}, want})
            note_failure($sformatf("code point expected 0x%06h, got 0x%06h",
                                   want, out_tdata));
        end
      end
      // byte transaction updates the local decoder
      if (in_tvalid && in_tready) begin
        row = offer_q.pop_front();
        got = decode_next_byte(in_tdata, in_tlast, cp_pred);
        case (row.check)
          CHK_MODEL: if (got) cp_expect_q = {cp_expect_q, cp_pred};
          CHK_CP:    cp_expect_q = {cp_expect_q, row.cp};
          default:   ;
        endcase
        accepted_cnt++;
      end
      // no progress for too long ends the run
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [BYTE_W-1:0] b;
    int unsigned       pick;
    int unsigned       len;
    int unsigned       nconts;
    int unsigned       i;
    bit                eot;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    pend_cnt       = NEED_NONE;
    pend_bits      = '0;
    fail_cnt       = 0;
    accepted_cnt   = 0;
    sent_cnt       = 0;
    stall_cycles   = 0;
    hold_cycles    = 0;
    long_hold_done = 1'b0;
    calm           = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // byte classes and extremes
    add_row(8'h00, 1'b0, CHK_CP,    21'h000000);
    add_row(8'h7F, 1'b0, CHK_CP,    21'h00007F);
    add_row(8'h80, 1'b0, CHK_NONE,  '0);  // stray continuation
    add_row(8'hBF, 1'b0, CHK_NONE,  '0);
    add_row(8'hFF, 1'b0, CHK_NONE,  '0);  // invalid lead
    add_row(8'hF8, 1'b0, CHK_NONE,  '0);
    // two- and three-byte sequences
    add_row(8'hC2, 1'b0, CHK_NONE,  '0);
    add_row(8'hA9, 1'b0, CHK_MODEL, '0);
    add_row(8'hE2, 1'b0, CHK_NONE,  '0);
    add_row(8'h82, 1'b0, CHK_NONE,  '0);
    add_row(8'hAC, 1'b0, CHK_MODEL, '0);
    // largest four-byte value
    add_row(8'hF7, 1'b0, CHK_NONE,  '0);
    add_row(8'hBF, 1'b0, CHK_NONE,  '0);
    add_row(8'hBF, 1'b0, CHK_NONE,  '0);
    add_row(8'hBF, 1'b0, CHK_CP,    21'h1FFFFF);
    // overlong zero is accepted
    add_row(8'hC0, 1'b0, CHK_NONE,  '0);
    add_row(8'h80, 1'b0, CHK_CP,    21'h000000);
    // interrupted sequence, the ascii byte still comes out
    add_row(8'hE3, 1'b0, CHK_NONE,  '0);
    add_row(8'h41, 1'b0, CHK_CP,    21'h000041);
    // truncated by end of string
    add_row(8'hF0, 1'b0, CHK_NONE,  '0);
    add_row(8'h90, 1'b1, CHK_NONE,  '0);
    // surrogate is accepted, then an ascii end of string
    add_row(8'hED, 1'b0, CHK_NONE,  '0);
    add_row(8'hA0, 1'b0, CHK_NONE,  '0);
    add_row(8'h80, 1'b0, CHK_MODEL, '0);
    add_row(8'h41, 1'b1, CHK_CP,    21'h000041);
    foreach (dir_rows[k])
      send_byte(dir_rows[k]);

    // random strings: mostly well formed, some broken, some noise
    sent_cnt = 0;
    while (sent_cnt < RANDOM_BYTES) begin
      calm = (sent_cnt >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        if (pick < 70) begin
          len    = $urandom_range(1, 4);
          nconts = len - 1;
        end else begin
          len    = $urandom_range(2, 4);
          nconts = $urandom_range(0, len - 2);
        end
        case (len)
          1:       b = 8'($urandom_range(0, 127));
          2:       b = LEAD2_MATCH | (8'($urandom) & ~LEAD2_MASK);
          3:       b = LEAD3_MATCH | (8'($urandom) & ~LEAD3_MASK);
          default: b = LEAD4_MATCH | (8'($urandom) & ~LEAD4_MASK);
        endcase
        for (i = 0; i <= nconts; i++) begin
          if (i != 0)
            b = CONT_MATCH | (8'($urandom) & ~CONT_MASK);
          eot = ($urandom_range(0, 19) == 0) ||
                (i == nconts && pick < 70 && $urandom_range(0, 7) == 0);
          send_byte(mk_row(b, eot, CHK_MODEL, '0));
        end
      end else begin
        len = $urandom_range(1, 3);
        repeat (len)
          send_byte(mk_row(8'($urandom), $urandom_range(0, 9) == 0, CHK_MODEL, '0));
      end
    end
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;

    // drain, then let the pipeline settle
    while (cp_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && cp_expect_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
sv/ucd_pkg.sv
sv/utf8_codepoint_decoder.sv
tb/testbench.sv
